@@ rtl/core/pph_pkg.sv @@
// ----------------------------------------------------------------------------
// Pinhole pixel reprojection package
// Shared types, register codes, pipeline depths and saturation helper.
// ----------------------------------------------------------------------------
package pph_pkg;

  localparam int unsigned CfgIdxW  = 3;
  localparam int unsigned CfgDataW = 64;
  localparam int unsigned QuotW    = 41;
  localparam int unsigned XformLat = 4;
  localparam int unsigned DivLat   = QuotW + 4;
  localparam int unsigned ProjLat  = DivLat + 2;
  localparam int unsigned Latency  = XformLat + ProjLat;

  localparam logic signed [31:0] SatMax = 32'sh7fff_ffff;
  localparam logic signed [31:0] SatMin = 32'sh8000_0000;
  localparam logic [QuotW-1:0]   QuotLimit = {1'b1, {(QuotW-1){1'b0}}};

  typedef enum logic [CfgIdxW-1:0] {
    CFG_ROT0,
    CFG_ROT1,
    CFG_ROT2,
    CFG_TRANS,
    CFG_FOCAL,
    CFG_PP,
    CFG_INV_FOCAL,
    CFG_SCALED_PP
  } cfg_idx_e;

  typedef struct packed {
    logic signed [31:0] source_u;
    logic signed [31:0] source_v;
    logic [15:0]        inverse_depth;
  } in_item_t;

  typedef struct packed {
    logic signed [31:0] warped_u;
    logic signed [31:0] warped_v;
    logic signed [31:0] point_x;
    logic signed [31:0] point_y;
    logic signed [31:0] point_z;
    logic               depth_zero;
  } out_item_t;

  typedef struct packed {
    logic signed [31:0] x;
    logic signed [31:0] y;
    logic signed [31:0] z;
  } point_t;

  typedef struct packed {
    logic signed [15:0] r00;
    logic signed [15:0] r01;
    logic signed [15:0] r02;
    logic signed [15:0] r10;
    logic signed [15:0] r11;
    logic signed [15:0] r12;
    logic signed [15:0] r20;
    logic signed [15:0] r21;
    logic signed [15:0] r22;
    logic signed [15:0] tx;
    logic signed [15:0] ty;
    logic signed [15:0] tz;
    logic [31:0]        fx;
    logic [31:0]        fy;
    logic signed [31:0] cx;
    logic signed [31:0] cy;
    logic [31:0]        ifx;
    logic [31:0]        ify;
    logic signed [31:0] spx;
    logic signed [31:0] spy;
  } cfg_t;

  function automatic logic signed [31:0] sat32(input logic signed [63:0] x);
    if (x > 64'sd2147483647) begin
      return SatMax;
    end
    if (x < -64'sd2147483648) begin
      return SatMin;
    end
    return x[31:0];
  endfunction

endpackage

@@ rtl/core/pinhole_pixel_reprojection.sv @@
// ----------------------------------------------------------------------------
// Pinhole pixel reprojection
// Warps a source pixel with inverse depth into the target camera.
// ----------------------------------------------------------------------------
// Input: present a pixel on item_i with start high; it is taken at every
// clock edge where start is high and busy is low. busy stays low, so a new
// pixel may enter in every cycle.
// Output: each pixel gives one result on result_o, marked by done_o for
// exactly one cycle, once it has passed 4 transform stages, a product
// stage, 45 divider stages (one quotient bit per step stage) and the output
// register. Sustained rate is one pixel per clock.
// The receiver cannot stall; results are never held or repeated.
// Configuration: write registers through cfg_we_i / cfg_idx_i / cfg_wdata_i
// while no pixel is in flight; writes take effect at once.
// Reset: rst_ni clears all in-flight transactions and loads identity
// rotation, zero translation and unit focal lengths.
// ----------------------------------------------------------------------------
module pinhole_pixel_reprojection (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          start,
  output logic                          busy,
  input  pph_pkg::in_item_t             item_i,
  output logic                          done_o,
  output pph_pkg::out_item_t            result_o,
  input  logic                          cfg_we_i,
  input  logic [pph_pkg::CfgIdxW-1:0]   cfg_idx_i,
  input  logic [pph_pkg::CfgDataW-1:0]  cfg_wdata_i
);
  import pph_pkg::*;

  cfg_t   cfg;
  logic   xf_valid;
  point_t xf_point;

  assign busy = 1'b0;

  pph_cfg_regs u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .cfg_o       (cfg)
  );

  pph_xform u_xform (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (start && !busy),
    .item_i  (item_i),
    .cfg_i   (cfg),
    .valid_o (xf_valid),
    .point_o (xf_point)
  );

  pph_proj u_proj (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .valid_i  (xf_valid),
    .point_i  (xf_point),
    .cfg_i    (cfg),
    .valid_o  (done_o),
    .result_o (result_o)
  );

  a_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy) |-> ##Latency done_o)
    else $error("result missing after accepted transaction");

  a_no_spurious: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> $past(start && !busy, Latency))
    else $error("result without accepted transaction");

  a_zero_flag: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> (result_o.depth_zero == (result_o.point_z == 32'sd0)))
    else $error("depth_zero does not match point_z");

  a_zero_sat: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && result_o.depth_zero) |->
      (result_o.warped_u == (result_o.point_x[31] ? SatMin : SatMax)))
    else $error("warped_u not saturated at zero depth");

endmodule

@@ rtl/core/pph_cfg_regs.sv @@
// ----------------------------------------------------------------------------
// Configuration registers
// Write-only register file; decodes packed fields for the datapath.
// ----------------------------------------------------------------------------
module pph_cfg_regs (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [pph_pkg::CfgIdxW-1:0]   cfg_idx_i,
  input  logic [pph_pkg::CfgDataW-1:0]  cfg_wdata_i,
  output pph_pkg::cfg_t                 cfg_o
);
  import pph_pkg::*;

  logic [47:0] rot0_q, rot1_q, rot2_q, trans_q;
  logic [63:0] focal_q, pp_q, ifocal_q, spp_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rot0_q   <= 48'h0000_0000_4000;
      rot1_q   <= 48'h0000_4000_0000;
      rot2_q   <= 48'h4000_0000_0000;
      trans_q  <= 48'h0;
      focal_q  <= 64'h0001_0000_0001_0000;
      pp_q     <= 64'h0;
      ifocal_q <= 64'h0100_0000_0100_0000;
      spp_q    <= 64'h0;
    end else if (cfg_we_i) begin
      case (cfg_idx_e'(cfg_idx_i))
        CFG_ROT0:      rot0_q   <= cfg_wdata_i[47:0];
        CFG_ROT1:      rot1_q   <= cfg_wdata_i[47:0];
        CFG_ROT2:      rot2_q   <= cfg_wdata_i[47:0];
        CFG_TRANS:     trans_q  <= cfg_wdata_i[47:0];
        CFG_FOCAL:     focal_q  <= cfg_wdata_i;
        CFG_PP:        pp_q     <= cfg_wdata_i;
        CFG_INV_FOCAL: ifocal_q <= cfg_wdata_i;
        CFG_SCALED_PP: spp_q    <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  always_comb begin
    cfg_o.r00 = rot0_q[15:0];
    cfg_o.r01 = rot0_q[31:16];
    cfg_o.r02 = rot0_q[47:32];
    cfg_o.r10 = rot1_q[15:0];
    cfg_o.r11 = rot1_q[31:16];
    cfg_o.r12 = rot1_q[47:32];
    cfg_o.r20 = rot2_q[15:0];
    cfg_o.r21 = rot2_q[31:16];
    cfg_o.r22 = rot2_q[47:32];
    cfg_o.tx  = trans_q[15:0];
    cfg_o.ty  = trans_q[31:16];
    cfg_o.tz  = trans_q[47:32];
    cfg_o.fx  = focal_q[31:0];
    cfg_o.fy  = focal_q[63:32];
    cfg_o.cx  = pp_q[31:0];
    cfg_o.cy  = pp_q[63:32];
    cfg_o.ifx = ifocal_q[31:0];
    cfg_o.ify = ifocal_q[63:32];
    cfg_o.spx = spp_q[31:0];
    cfg_o.spy = spp_q[63:32];
  end

endmodule

@@ rtl/core/pph_xform.sv @@
// ----------------------------------------------------------------------------
// Back-projection and rigid transform
// Four stages: scale, normalize, multiply, accumulate into a Q8.24 point.
// ----------------------------------------------------------------------------
module pph_xform (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              valid_i,
  input  pph_pkg::in_item_t item_i,
  input  pph_pkg::cfg_t     cfg_i,
  output logic              valid_o,
  output pph_pkg::point_t   point_o
);
  import pph_pkg::*;

  logic [XformLat-1:0] vld_q;

  logic signed [64:0] mu_d, mv_d;
  logic signed [63:0] mu_q, mv_q;
  logic [15:0]        d1_q, d2_q;

  logic signed [63:0] nu_s, nv_s;
  logic signed [31:0] xn_q, yn_q;

  logic signed [15:0] rot [3][3];
  logic signed [15:0] tr  [3];
  logic signed [47:0] prod_d [3][2];
  logic signed [47:0] prod_q [3][2];
  logic signed [32:0] td_d [3];
  logic signed [32:0] td_q [3];
  logic signed [63:0] acc [3];
  logic signed [63:0] rnd [3];
  logic signed [31:0] pt_d [3];
  point_t             point_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      vld_q <= {vld_q[XformLat-2:0], valid_i};
    end
  end

  assign mu_d = item_i.source_u * $signed({1'b0, cfg_i.ifx});
  assign mv_d = item_i.source_v * $signed({1'b0, cfg_i.ify});

  always_comb begin
    nu_s = (mu_q >>> 16) + $signed({63'd0, mu_q[15]}) - 64'(cfg_i.spx);
    nv_s = (mv_q >>> 16) + $signed({63'd0, mv_q[15]}) - 64'(cfg_i.spy);
  end

  always_comb begin
    rot[0][0] = cfg_i.r00; rot[0][1] = cfg_i.r01; rot[0][2] = cfg_i.r02;
    rot[1][0] = cfg_i.r10; rot[1][1] = cfg_i.r11; rot[1][2] = cfg_i.r12;
    rot[2][0] = cfg_i.r20; rot[2][1] = cfg_i.r21; rot[2][2] = cfg_i.r22;
    tr[0] = cfg_i.tx;
    tr[1] = cfg_i.ty;
    tr[2] = cfg_i.tz;
    for (int r = 0; r < 3; r++) begin
      prod_d[r][0] = rot[r][0] * xn_q;
      prod_d[r][1] = rot[r][1] * yn_q;
      td_d[r]      = tr[r] * $signed({1'b0, d2_q});
      acc[r] = 64'(prod_q[r][0]) + 64'(prod_q[r][1]) + (64'(rot[r][2]) <<< 24)
             + (64'(td_q[r]) <<< 18);
      rnd[r] = (acc[r] >>> 14) + $signed({63'd0, acc[r][13]});
      pt_d[r] = sat32(rnd[r]);
    end
  end

  always_ff @(posedge clk_i) begin
    mu_q <= mu_d[63:0];
    mv_q <= mv_d[63:0];
    d1_q <= item_i.inverse_depth;
    xn_q <= sat32(nu_s);
    yn_q <= sat32(nv_s);
    d2_q <= d1_q;
    prod_q <= prod_d;
    td_q   <= td_d;
    point_q.x <= pt_d[0];
    point_q.y <= pt_d[1];
    point_q.z <= pt_d[2];
  end

  assign valid_o = vld_q[XformLat-1];
  assign point_o = point_q;

endmodule

@@ rtl/core/pph_div.sv @@
// ----------------------------------------------------------------------------
// Pipelined rounding divider
// Rounds |num|/|den| to nearest, clamps to 2^40 and restores the sign;
// one quotient bit per step stage after the sign and rounding stages.
// ----------------------------------------------------------------------------
module pph_div (
  input  logic                     clk_i,
  input  logic signed [63:0]       num_i,
  input  logic signed [31:0]       den_i,
  output logic signed [pph_pkg::QuotW:0] quot_o
);
  import pph_pkg::*;

  logic [63:0] an_q, n_q;
  logic [31:0] ad1_q, ad2_q;
  logic        neg1_q, neg2_q;

  logic [31:0]      rem_q [QuotW+1];
  logic [QuotW-1:0] lo_q  [QuotW+1];
  logic [QuotW-1:0] q_q   [QuotW+1];
  logic [31:0]      ad_q  [QuotW+1];
  logic             neg_q [QuotW+1];
  logic             ovf_q [QuotW+1];

  logic [QuotW-1:0]      uq;
  logic signed [QuotW:0] quot_q;

  always_ff @(posedge clk_i) begin
    an_q   <= num_i[63] ? (~num_i + 64'd1) : num_i;
    ad1_q  <= den_i[31] ? (~den_i + 32'd1) : den_i;
    neg1_q <= num_i[63] ^ den_i[31];
    n_q    <= an_q + {33'd0, ad1_q[31:1]};
    ad2_q  <= ad1_q;
    neg2_q <= neg1_q;
    rem_q[0] <= {9'd0, n_q[63:QuotW]};
    lo_q[0]  <= n_q[QuotW-1:0];
    q_q[0]   <= '0;
    ad_q[0]  <= ad2_q;
    neg_q[0] <= neg2_q;
    ovf_q[0] <= {9'd0, n_q[63:QuotW]} >= ad2_q;
  end

  for (genvar s = 1; s <= QuotW; s++) begin : g_step
    logic [32:0] trial;
    logic        take;
    assign trial = {rem_q[s-1], lo_q[s-1][QuotW-s]};
    assign take  = trial >= {1'b0, ad_q[s-1]};
    always_ff @(posedge clk_i) begin
      rem_q[s] <= take ? 32'(trial - {1'b0, ad_q[s-1]}) : trial[31:0];
      q_q[s]   <= {q_q[s-1][QuotW-2:0], take};
      lo_q[s]  <= lo_q[s-1];
      ad_q[s]  <= ad_q[s-1];
      neg_q[s] <= neg_q[s-1];
      ovf_q[s] <= ovf_q[s-1];
    end
  end

  assign uq = (ovf_q[QuotW] || q_q[QuotW] > QuotLimit) ? QuotLimit : q_q[QuotW];

  always_ff @(posedge clk_i) begin
    quot_q <= neg_q[QuotW] ? -$signed({1'b0, uq}) : $signed({1'b0, uq});
  end

  assign quot_o = quot_q;

endmodule

@@ rtl/core/pph_proj.sv @@
// ----------------------------------------------------------------------------
// Perspective projection
// Scales the point by the focal lengths, divides by z, adds the principal
// point and saturates; handles zero depth.
// ----------------------------------------------------------------------------
module pph_proj (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               valid_i,
  input  pph_pkg::point_t    point_i,
  input  pph_pkg::cfg_t      cfg_i,
  output logic               valid_o,
  output pph_pkg::out_item_t result_o
);
  import pph_pkg::*;

  logic signed [64:0] nx_d, ny_d;
  logic signed [63:0] nx_q, ny_q;
  logic signed [31:0] z_q;
  point_t             pt_q;
  logic               v1_q;

  logic signed [QuotW:0] qx, qy;

  point_t      side_q [DivLat];
  logic [DivLat-1:0] side_v_q;

  point_t             pt_e;
  logic               zero_e;
  logic signed [63:0] sum_x, sum_y;
  out_item_t          res_d, res_q;
  logic               res_v_q;

  assign nx_d = point_i.x * $signed({1'b0, cfg_i.fx});
  assign ny_d = point_i.y * $signed({1'b0, cfg_i.fy});

  always_ff @(posedge clk_i) begin
    nx_q <= nx_d[63:0];
    ny_q <= ny_d[63:0];
    z_q  <= point_i.z;
    pt_q <= point_i;
  end

  pph_div u_div_x (
    .clk_i  (clk_i),
    .num_i  (nx_q),
    .den_i  (z_q),
    .quot_o (qx)
  );

  pph_div u_div_y (
    .clk_i  (clk_i),
    .num_i  (ny_q),
    .den_i  (z_q),
    .quot_o (qy)
  );

  always_ff @(posedge clk_i) begin
    side_q[0] <= pt_q;
    for (int k = 1; k < DivLat; k++) begin
      side_q[k] <= side_q[k-1];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q     <= 1'b0;
      side_v_q <= '0;
      res_v_q  <= 1'b0;
    end else begin
      v1_q     <= valid_i;
      side_v_q <= {side_v_q[DivLat-2:0], v1_q};
      res_v_q  <= side_v_q[DivLat-1];
    end
  end

  always_comb begin
    pt_e   = side_q[DivLat-1];
    zero_e = (pt_e.z == 32'sd0);
    sum_x  = 64'(qx) + 64'(cfg_i.cx);
    sum_y  = 64'(qy) + 64'(cfg_i.cy);
    res_d.point_x    = pt_e.x;
    res_d.point_y    = pt_e.y;
    res_d.point_z    = pt_e.z;
    res_d.depth_zero = zero_e;
    if (zero_e) begin
      res_d.warped_u = pt_e.x[31] ? SatMin : SatMax;
      res_d.warped_v = pt_e.y[31] ? SatMin : SatMax;
    end else begin
      res_d.warped_u = sat32(sum_x);
      res_d.warped_v = sat32(sum_y);
    end
  end

  always_ff @(posedge clk_i) begin
    res_q <= res_d;
  end

  assign valid_o  = res_v_q;
  assign result_o = res_q;

endmodule

@@ test/tb.sv @@
// ----------------------------------------------------------------------------
// Pinhole reprojection testbench
// Drives pixels through the warp pipeline under several camera setups,
// predicts each warped pixel and intermediate point in fixed point, and
// checks every result in order. Random gaps on the input side; the output
// side cannot stall.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb;
  import pph_pkg::*;

  typedef logic signed [127:0] wide_t;

  localparam int unsigned IdleLimit = 5000;

  logic         clk_i;
  logic         rst_ni;
  logic         start;
  logic         busy;
  in_item_t     item_i;
  logic         done_o;
  out_item_t    result_o;
  logic         cfg_we_i;
  logic [CfgIdxW-1:0]  cfg_idx_i;
  logic [CfgDataW-1:0] cfg_wdata_i;

  logic [63:0]  cam_regs [8];
  out_item_t    warp_q [$];
  int unsigned  n_fail;
  int unsigned  idle_cycles;

  pinhole_pixel_reprojection i_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start      (start),
    .busy       (busy),
    .item_i     (item_i),
    .done_o     (done_o),
    .result_o   (result_o),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_wdata_i(cfg_wdata_i)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  function automatic wide_t round_half_up(wide_t x, int k);
    return (x >>> k) + ((x >>> (k - 1)) & wide_t'(1));
  endfunction

  function automatic wide_t clamp32(wide_t x);
    if (x > wide_t'(32'sh7fff_ffff)) return wide_t'(32'sh7fff_ffff);
    if (x < -wide_t'(64'sd2147483648)) return -wide_t'(64'sd2147483648);
    return x;
  endfunction

  function automatic wide_t sfield(logic [63:0] r, int lsb, int bits);
    logic [63:0] s;
    s = (r >> lsb) << (64 - bits);
    return wide_t'($signed(s) >>> (64 - bits));
  endfunction

  function automatic wide_t rotate_row(logic [63:0] row, wide_t xn, wide_t yn,
                                       wide_t t, wide_t d);
    wide_t acc;
    acc = sfield(row, 0, 16) * xn + sfield(row, 16, 16) * yn
        + sfield(row, 32, 16) * (wide_t'(1) << 24);
    acc = acc + t * d * (wide_t'(1) << 18);
    return clamp32(round_half_up(acc, 14));
  endfunction

  function automatic wide_t project_axis(wide_t p, wide_t z, wide_t f, wide_t c);
    wide_t num, an, ad, uq;
    if (z == 0) return (p < 0) ? -wide_t'(64'sd2147483648) : wide_t'(32'sh7fff_ffff);
    num = p * f;
    an  = (num < 0) ? -num : num;
    ad  = (z < 0) ? -z : z;
    uq  = (an + ad / 2) / ad;
    if (uq > (wide_t'(1) << 40)) uq = wide_t'(1) << 40;
    if ((num < 0) != (z < 0)) uq = -uq;
    return clamp32(uq + c);
  endfunction

  function automatic out_item_t predict_warp(in_item_t px_in);
    wide_t u, v, d, xn, yn, px, py, pz;
    out_item_t r;
    u  = wide_t'(px_in.source_u);
    v  = wide_t'(px_in.source_v);
    d  = wide_t'({1'b0, px_in.inverse_depth});
    xn = clamp32(round_half_up(u * wide_t'({1'b0, cam_regs[CFG_INV_FOCAL][31:0]}), 16)
                 - sfield(cam_regs[CFG_SCALED_PP], 0, 32));
    yn = clamp32(round_half_up(v * wide_t'({1'b0, cam_regs[CFG_INV_FOCAL][63:32]}), 16)
                 - sfield(cam_regs[CFG_SCALED_PP], 32, 32));
    px = rotate_row(cam_regs[CFG_ROT0], xn, yn, sfield(cam_regs[CFG_TRANS], 0, 16), d);
    py = rotate_row(cam_regs[CFG_ROT1], xn, yn, sfield(cam_regs[CFG_TRANS], 16, 16), d);
    pz = rotate_row(cam_regs[CFG_ROT2], xn, yn, sfield(cam_regs[CFG_TRANS], 32, 16), d);
    r.warped_u   = 32'(project_axis(px, pz, wide_t'({1'b0, cam_regs[CFG_FOCAL][31:0]}),
                                    sfield(cam_regs[CFG_PP], 0, 32)));
    r.warped_v   = 32'(project_axis(py, pz, wide_t'({1'b0, cam_regs[CFG_FOCAL][63:32]}),
                                    sfield(cam_regs[CFG_PP], 32, 32)));
    r.point_x    = px[31:0];
    r.point_y    = py[31:0];
    r.point_z    = pz[31:0];
    r.depth_zero = (pz == 0);
    return r;
  endfunction

  task automatic check_field(string name, logic [31:0] exp_v, logic [31:0] act_v);
    if (exp_v !== act_v) begin
      $error("%s: expected %h, got %h", name, exp_v, act_v);
      n_fail++;
    end
  endtask

  always @(posedge clk_i) begin
    out_item_t exp_r;
    if (rst_ni && done_o) begin
      if (warp_q.size() == 0) begin
        $error("result with nothing pending");
        n_fail++;
      end else begin
        exp_r = warp_q.pop_front();
        check_field("warped_u", exp_r.warped_u, result_o.warped_u);
        check_field("warped_v", exp_r.warped_v, result_o.warped_v);
        check_field("point_x", exp_r.point_x, result_o.point_x);
        check_field("point_y", exp_r.point_y, result_o.point_y);
        check_field("point_z", exp_r.point_z, result_o.point_z);
        check_field("depth_zero", 32'(exp_r.depth_zero), 32'(result_o.depth_zero));
      end
    end
  end

  always @(posedge clk_i) begin
    if (!rst_ni || (start && !busy) || done_o) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IdleLimit) begin
        $display("tb: failure");
        $finish;
      end
    end
  end

  task automatic cfg_write(cfg_idx_e idx, logic [63:0] val);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= idx;
    cfg_wdata_i <= val;
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
    cam_regs[idx] = (idx <= CFG_TRANS) ? {16'h0, val[47:0]} : val;
    @(posedge clk_i);
  endtask

  task automatic wait_drain();
    start <= 1'b0;
    while (warp_q.size() != 0) @(posedge clk_i);
    repeat (Latency + 2) @(posedge clk_i);
  endtask

  task automatic send_pixel(logic [31:0] u, logic [31:0] v, logic [15:0] d);
    int unsigned gap;
    item_i <= '{source_u: u, source_v: v, inverse_depth: d};
    start  <= 1'b1;
    do @(posedge clk_i); while (busy);
    warp_q.push_back(predict_warp('{source_u: u, source_v: v, inverse_depth: d}));
    gap = ($urandom_range(0, 2) == 0) ? 0
        : ($urandom_range(0, 15) == 0) ? $urandom_range(10, 120) : $urandom_range(0, 3);
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
  endtask

  task automatic set_camera_real();
    logic [31:0] fx, fy, cx, cy;
    logic [15:0] r [9];
    for (int i = 0; i < 9; i++) begin
      r[i] = (i % 4 == 0) ? 16'(16384 - $urandom_range(0, 600))
                          : 16'($signed($urandom_range(0, 3000)) - 1500);
    end
    fx = {16'($urandom_range(100, 900)), 16'($urandom)};
    fy = {16'($urandom_range(100, 900)), 16'($urandom)};
    cx = {16'($urandom_range(0, 640)), 16'($urandom)};
    cy = {16'($urandom_range(0, 480)), 16'($urandom)};
    cfg_write(CFG_ROT0, 64'({r[2], r[1], r[0]}));
    cfg_write(CFG_ROT1, 64'({r[5], r[4], r[3]}));
    cfg_write(CFG_ROT2, 64'({r[8], r[7], r[6]}));
    cfg_write(CFG_TRANS, 64'({16'($signed($urandom_range(0, 512)) - 256),
                              16'($signed($urandom_range(0, 512)) - 256),
                              16'($signed($urandom_range(0, 512)) - 256)}));
    cfg_write(CFG_FOCAL, {fy, fx});
    cfg_write(CFG_PP, {cy, cx});
    cfg_write(CFG_INV_FOCAL, {32'((64'd1 << 40) / fy), 32'((64'd1 << 40) / fx)});
    cfg_write(CFG_SCALED_PP, {32'(({32'd0, cy} << 24) / fy), 32'(({32'd0, cx} << 24) / fx)});
  endtask

  task automatic set_camera_wild();
    for (int i = 0; i < 8; i++) begin
      cfg_write(cfg_idx_e'(i), {$urandom, $urandom});
    end
  endtask

  task automatic send_random_pixels(int unsigned n);
    for (int unsigned k = 0; k < n; k++) begin
      if ($urandom_range(0, 3) == 0) begin
        send_pixel($urandom, $urandom, 16'($urandom));
      end else begin
        send_pixel({16'($urandom_range(0, 640)), 16'($urandom)},
                   {16'($urandom_range(0, 480)), 16'($urandom)},
                   16'($urandom_range(0, 12000)));
      end
    end
  endtask

  task automatic test_default_camera();
    send_pixel(32'h0000_0000, 32'h0000_0000, 16'h0000);
    send_pixel(32'h7fff_ffff, 32'h8000_0000, 16'hffff);
    send_pixel(32'h8000_0000, 32'h7fff_ffff, 16'h0001);
    send_pixel(32'hffff_ffff, 32'h0000_0001, 16'h1000);
    send_pixel(32'h0140_0000, 32'h00f0_8000, 16'h0800);
    wait_drain();
  endtask

  task automatic test_zero_depth();
    cfg_write(CFG_TRANS, 64'h0000_ff00_0100_0100);
    send_pixel(32'h0001_0000, 32'hffff_0000, 16'h1000);
    send_pixel(32'hfff0_0000, 32'h0020_0000, 16'h1000);
    send_pixel(32'h0000_0000, 32'h0000_0000, 16'h1000);
    wait_drain();
    cfg_write(CFG_ROT2, 64'h0);
    cfg_write(CFG_TRANS, 64'h0);
    send_pixel(32'h0005_0000, 32'hfffb_0000, 16'h0000);
    send_pixel(32'hfffb_0000, 32'h0005_0000, 16'hffff);
    wait_drain();
  endtask

  task automatic test_register_extremes();
    cfg_write(CFG_ROT0, 64'h0000_7fff_7fff_7fff);
    cfg_write(CFG_ROT1, 64'h0000_8000_8000_8000);
    cfg_write(CFG_ROT2, 64'h0000_0001_0000_0000);
    cfg_write(CFG_TRANS, 64'h0000_8000_7fff_8000);
    cfg_write(CFG_FOCAL, 64'hffff_ffff_ffff_ffff);
    cfg_write(CFG_PP, 64'h7fff_ffff_8000_0000);
    cfg_write(CFG_INV_FOCAL, 64'hffff_ffff_ffff_ffff);
    cfg_write(CFG_SCALED_PP, 64'h8000_0000_7fff_ffff);
    send_pixel(32'h7fff_ffff, 32'h7fff_ffff, 16'hffff);
    send_pixel(32'h8000_0000, 32'h8000_0000, 16'hffff);
    send_pixel(32'h0000_0100, 32'hffff_ff00, 16'h0000);
    wait_drain();
    cfg_write(CFG_FOCAL, 64'h0);
    cfg_write(CFG_INV_FOCAL, 64'h0);
    cfg_write(CFG_ROT2, 64'h0000_4000_0000_0000);
    send_pixel(32'h1234_5678, 32'hedcb_a987, 16'h8000);
    send_pixel(32'h0000_0000, 32'h0000_0000, 16'h0000);
    wait_drain();
  endtask

  task automatic test_random_cameras();
    for (int ph = 0; ph < 8; ph++) begin
      if (ph % 4 == 3) set_camera_wild();
      else set_camera_real();
      send_random_pixels(140);
      wait_drain();
    end
  endtask

  initial begin
    n_fail      = 0;
    rst_ni      = 1'b0;
    start       = 1'b0;
    item_i      = '0;
    cfg_we_i    = 1'b0;
    cfg_idx_i   = '0;
    cfg_wdata_i = '0;
    cam_regs[CFG_ROT0]      = 64'h4000;
    cam_regs[CFG_ROT1]      = 64'h4000_0000;
    cam_regs[CFG_ROT2]      = 64'h4000_0000_0000;
    cam_regs[CFG_TRANS]     = 64'h0;
    cam_regs[CFG_FOCAL]     = 64'h0001_0000_0001_0000;
    cam_regs[CFG_PP]        = 64'h0;
    cam_regs[CFG_INV_FOCAL] = 64'h0100_0000_0100_0000;
    cam_regs[CFG_SCALED_PP] = 64'h0;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_default_camera();
    test_zero_depth();
    test_register_extremes();
    test_random_cameras();
    wait_drain();
    if (n_fail == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
